FILE: sv/tmps_pkg.sv
// ============================================================================
// tmps_pkg: shared types and constants for the triangle max path sum core
// Row store sizing, field widths and the stage-1 request record.
// ============================================================================
`default_nettype none

package tmps_pkg;

    localparam int MAX_ROWS = 64;
    localparam int COL_W    = $clog2(MAX_ROWS);       // column index into row store
    localparam int CNT_W    = $clog2(MAX_ROWS + 1);   // row counter, holds MAX_ROWS
    localparam int CFG_W    = 7;                      // row_count register width
    localparam int VAL_W    = 16;
    localparam int SUM_W    = 22;

    localparam logic [SUM_W-1:0] SUM_MAX         = {SUM_W{1'b1}};
    localparam logic [CFG_W-1:0] ROW_COUNT_RESET = 7'd15;

    // register indexes
    localparam int REG_ROW_COUNT = 0;
    localparam int REG_COUNT     = 1;

    // request in the compute stage
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [VAL_W-1:0] value;
        logic             has_above;  // column < row: slot above is valid
        logic             has_left;   // column > 0: slot above-left is valid
        logic             last_row;   // base row: feeds running maximum
        logic             tri_end;    // last entry of the triangle
        logic             fwd;        // slot written by previous request, use bypass
    } tmps_stage_t;

    // row_count of zero means one row, above MAX_ROWS means MAX_ROWS
    function automatic logic [CNT_W-1:0] eff_rows(input logic [CFG_W-1:0] rc);
        int n;
        n = int'(rc);
        if (n == 0)
        begin
            n = 1;
        end
        if (n > MAX_ROWS)
        begin
            n = MAX_ROWS;
        end
        return CNT_W'(n);
    endfunction

endpackage

`default_nettype wire

FILE: sv/triangle_max_path_sum_core.sv
// ============================================================================
// triangle_max_path_sum_core
// Streams triangle entries row by row from the apex and returns the largest
// apex-to-base path sum after the last entry of each triangle.
// ============================================================================
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+-----------------------------------------
//  s_*     | in  | s_tvalid/tready  | s_tdata[15:0]  value
//  m_*     | out | m_tvalid/tready  | m_tdata[21:0]  best_total
//  apb     | in  | psel/penable     | 0x0 row_count[6:0]
//
//  One entry per cycle while s_tready is high. An entry is accepted in
//  stage 0 (row store read issued), summed and written back in stage 1;
//  best_total is in the output register the cycle after the last sum.
//  The row store has one read and one write port; the only same-slot overlap
//  (column 0 right after a one-entry row) goes through a bypass register.
//  s_tready drops only while the compute stage holds a triangle end and the
//  output register is still waiting on m_tready.
//  Reset clears counters, running maximum and valids; the row store is not
//  cleared, every slot is written before it is read. A row_count write
//  abandons the triangle in progress.
//
`default_nettype none

module triangle_max_path_sum_core
(
    input  wire         clk,
    input  wire         rst_n,

    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [15:0] s_tdata,    // [15:0] value

    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [23:0] m_tdata,    // [21:0] best_total, [23:22] zero

    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int COL_W = tmps_pkg::COL_W;
    localparam int CNT_W = tmps_pkg::CNT_W;
    localparam int SUM_W = tmps_pkg::SUM_W;
    localparam int VAL_W = tmps_pkg::VAL_W;
    localparam int CFG_W = tmps_pkg::CFG_W;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] row_count_reg;
    logic             cfg_wr;
    logic             cfg_sel_rc;

    assign pready     = 1'b1;
    assign cfg_sel_rc = (32'(paddr[2]) == tmps_pkg::REG_ROW_COUNT);
    assign cfg_wr     = psel && penable && pwrite && pready && cfg_sel_rc;

    always_comb
    begin
        prdata = '0;
        if (cfg_sel_rc)
        begin
            prdata = 32'(row_count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= tmps_pkg::ROW_COUNT_RESET;
        end
        else if (cfg_wr)
        begin
            row_count_reg <= pwdata[CFG_W-1:0];
        end
    end

    logic [CNT_W-1:0] rows;
    assign rows = tmps_pkg::eff_rows(row_count_reg);

    // ------------------------------------------------------------------
    // Stage 0: position tracking, row store read issue
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;

    logic                  s1_valid_reg;
    tmps_pkg::tmps_stage_t s1_reg;
    logic                  stall;
    logic                  commit;
    logic                  accept;

    logic                  row_end;
    logic                  last_row;
    tmps_pkg::tmps_stage_t s0_req;

    // compute stage can only back up when it holds a triangle end
    assign stall    = s1_valid_reg && s1_reg.tri_end && m_tvalid && !m_tready;
    assign commit   = s1_valid_reg && !stall;
    assign s_tready = !stall;
    assign accept   = s_tvalid && s_tready;

    assign row_end  = (CNT_W'(col_reg) == row_reg);
    assign last_row = ((row_reg + CNT_W'(1)) == rows);

    always_comb
    begin
        s0_req.col       = col_reg;
        s0_req.value     = s_tdata[VAL_W-1:0];
        s0_req.has_above = (CNT_W'(col_reg) < row_reg);
        s0_req.has_left  = (col_reg != '0);
        s0_req.last_row  = last_row;
        s0_req.tri_end   = row_end && last_row;
        // previous request writes this slot in the same cycle as our read
        s0_req.fwd       = s1_valid_reg && (s1_reg.col == col_reg);

        row_next = row_reg;
        col_next = col_reg;
        if (accept)
        begin
            if (row_end && last_row)
            begin
                row_next = '0;
                col_next = '0;
            end
            else if (row_end)
            begin
                row_next = row_reg + CNT_W'(1);
                col_next = '0;
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
        if (cfg_wr)
        begin
            row_next = '0;
            col_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (commit)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Row store: one read port (stage 0), one write port (stage 1)
    // ------------------------------------------------------------------
    logic [SUM_W-1:0] row_sums [tmps_pkg::MAX_ROWS];
    logic [SUM_W-1:0] rdata_reg;
    logic [SUM_W-1:0] fwd_data_reg;
    logic [SUM_W-1:0] sum;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rdata_reg    <= row_sums[col_reg];
            fwd_data_reg <= sum;
            s1_reg       <= s0_req;
        end
        if (commit)
        begin
            row_sums[s1_reg.col] <= sum;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: max of parents, saturating add, write back
    // ------------------------------------------------------------------
    logic [SUM_W-1:0] left_reg, left_next;
    logic [SUM_W-1:0] max_reg, max_next;
    logic [SUM_W-1:0] above;
    logic [SUM_W-1:0] best;
    logic [SUM_W:0]   sum_wide;
    logic [SUM_W-1:0] new_max;

    always_comb
    begin
        above = '0;
        if (s1_reg.has_above)
        begin
            above = s1_reg.fwd ? fwd_data_reg : rdata_reg;
        end
        best = (s1_reg.has_left && (left_reg > above)) ? left_reg : above;

        sum_wide = {1'b0, best} + (SUM_W + 1)'(s1_reg.value);
        sum      = sum_wide[SUM_W] ? tmps_pkg::SUM_MAX : sum_wide[SUM_W-1:0];

        new_max = (s1_reg.last_row && (sum > max_reg)) ? sum : max_reg;

        left_next = left_reg;
        max_next  = max_reg;
        if (commit)
        begin
            left_next = above;
            max_next  = s1_reg.tri_end ? '0 : new_max;
        end
        if (cfg_wr)
        begin
            left_next = '0;
            max_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0;
            max_reg  <= '0;
        end
        else
        begin
            left_reg <= left_next;
            max_reg  <= max_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic             out_valid_reg;
    logic [SUM_W-1:0] out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (commit && s1_reg.tri_end)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit && s1_reg.tri_end)
        begin
            out_data_reg <= new_max;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = 24'(out_data_reg);

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'(col_reg) <= row_reg)
        else $error("column index past row index");

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        !accept || (row_reg < rows))
        else $error("row index past configured row count");

    a_fwd_col0: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_reg.fwd) |-> (s1_reg.col == '0))
        else $error("bypass used away from row start");

    a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && s1_reg.tri_end) |=> m_tvalid)
        else $error("triangle end gave no result");

endmodule

`default_nettype wire
